/* rtl/core/swmd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swmd_pkg
// Shared constants and command/status types for the motion detector core.
// ----------------------------------------------------------------------------
package swmd_pkg;

  localparam int MAX_WINDOW  = 128;
  localparam int MIN_FILL    = 5;
  localparam int SAMPLE_BITS = 16;

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int MAG_W  = SAMPLE_BITS;
  localparam int MSQ_W  = 2 * SAMPLE_BITS + 2;
  localparam int SUM_W  = MAG_W + CNT_W - 1;
  localparam int SQS_W  = 2 * MAG_W + CNT_W - 1;
  localparam int ROOT_W = MSQ_W / 2;
  localparam int HALF_G = 1 << (SAMPLE_BITS - 5);

  localparam logic [0:0] REG_WINDOW    = 1'b0;
  localparam logic [0:0] REG_THRESHOLD = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture sample, compute squared magnitude and posture
    logic sqrt_start; // start the shared root (source chosen by sqrt_var)
    logic sqrt_var;   // with sqrt_start: take root of variance
    logic ring_rd;    // read old slot
    logic update;     // update ring and sums
    logic div_start;  // start both divisions
    logic var_calc;   // form variance
    logic result;     // latch result
    logic clear;      // clear window
  } swmd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic warm;      // fill count below MIN_FILL
  } swmd_stat_t;

endpackage
`default_nettype wire

/* rtl/core/sliding_window_motion_detector_core.sv */
`default_nettype none
// Items are taken one at a time: a new item is accepted only once the last
//   has reached the output registers. The work per item is the 17-step root
//   of the magnitude, two 39-step dividers and a second pass of the 17-step
//   root; while warming up the dividers and the second root are skipped.
//   A result waiting on the output does not hold off the next item.
// Reset: window cleared, window_length 64, threshold 205.
// ----------------------------------------------------------------------------
// sliding_window_motion_detector_core
// Top level: config registers, controller and datapath.
// ----------------------------------------------------------------------------
module sliding_window_motion_detector_core (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire signed [15:0] accel_x,
  input  wire signed [15:0] accel_y,
  input  wire signed [15:0] accel_z,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [15:0]       deviation,
  output logic              in_motion,
  output logic [1:0]        posture,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [0:0]        cfg_index,
  input  wire  [15:0]       cfg_data
);
  import swmd_pkg::*;

  swmd_cmd_t        cmd;
  swmd_stat_t       stat;
  logic [CNT_W-1:0] win_len;
  logic [15:0]      thresh;
  logic             clr_req;
  logic             cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign clr_req   = cfg_wr && (cfg_index == REG_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= CNT_W'(64);
      thresh  <= 16'd205;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_WINDOW: begin
          if (cfg_data[7:0] == 8'd0)                 win_len <= CNT_W'(1);
          else if (cfg_data[7:0] > 8'(MAX_WINDOW))   win_len <= CNT_W'(MAX_WINDOW);
          else                                       win_len <= CNT_W'(cfg_data[7:0]);
        end
        REG_THRESHOLD: begin
          if (cfg_data != 16'd0) thresh <= cfg_data;
        end
        default: ;
      endcase
    end
  end

  swmd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .clr_req, .cmd, .stat
  );

  swmd_datapath u_dp (
    .clk, .rst, .cmd, .stat, .win_len, .thresh,
    .accel_x, .accel_y, .accel_z,
    .deviation, .in_motion, .posture
  );

endmodule
`default_nettype wire

/* rtl/core/swmd_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swmd_ctrl
// Sequencer for one sample: root, ring update, then past warm-up divisions and variance root.
// ----------------------------------------------------------------------------
module swmd_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  input  wire                   clr_req,
  output swmd_pkg::swmd_cmd_t   cmd,
  input  swmd_pkg::swmd_stat_t  stat
);
  import swmd_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SQ0   = 10'b0000000010,
    S_SQW   = 10'b0000000100,
    S_UPD   = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_DIVW  = 10'b0000100000,
    S_VAR   = 10'b0001000000,
    S_VSQ   = 10'b0010000000,
    S_VSQW  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  // a result waiting in the output registers does not hold off the next item
  assign in_ready = (state == S_IDLE) && !clr_req;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.clear      = clr_req;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = S_SQ0;
        end
      end
      S_SQ0: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQW;
      end
      S_SQW: begin
        cmd.ring_rd = 1'b1;
        if (stat.sqrt_done) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.warm) begin
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVW;
        end
      end
      S_DIVW: begin
        if (stat.div_done) state_next = S_VAR;
      end
      S_VAR: begin
        cmd.var_calc = 1'b1;
        state_next   = S_VSQ;
      end
      S_VSQ: begin
        cmd.sqrt_start = 1'b1;
        cmd.sqrt_var   = 1'b1;
        state_next     = S_VSQW;
      end
      S_VSQW: begin
        if (stat.sqrt_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.result     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("input ready while busy");
  a_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_SQ0))
    else $error("load did not start sequence");
`endif

endmodule
`default_nettype wire

/* rtl/core/swmd_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swmd_datapath
// Ring memory, running sums, shared bit-serial root and two dividers.
// ----------------------------------------------------------------------------
module swmd_datapath (
  input  wire                          clk,
  input  wire                          rst,
  input  swmd_pkg::swmd_cmd_t          cmd,
  output swmd_pkg::swmd_stat_t         stat,
  input  wire  [swmd_pkg::CNT_W-1:0]   win_len,
  input  wire  [15:0]                  thresh,
  input  wire  signed [15:0]           accel_x,
  input  wire  signed [15:0]           accel_y,
  input  wire  signed [15:0]           accel_z,
  output logic [15:0]                  deviation,
  output logic                         in_motion,
  output logic [1:0]                   posture
);
  import swmd_pkg::*;

  localparam int SQ_STEPS = ROOT_W;
  localparam int DIV_W    = SQS_W;
  localparam int SC_W     = $clog2(SQ_STEPS + 1);
  localparam int DC_W     = $clog2(DIV_W + 1);

  logic [MAG_W-1:0] ring [MAX_WINDOW];
  logic [MAG_W-1:0] old_mag;
  logic [PTR_W-1:0] wptr;
  logic [CNT_W-1:0] fill;
  logic [SUM_W-1:0] msum;
  logic [SQS_W-1:0] ssum;
  logic             full;

  logic [MSQ_W-1:0] msq;
  logic [1:0]       post_r;

  // ---- posture from the captured sample
  logic signed [16:0] ax, ay, az;
  logic [1:0] post_c;
  always_comb begin
    ax = accel_x[15] ? -{accel_x[15], accel_x} : {accel_x[15], accel_x};
    ay = accel_y[15] ? -{accel_y[15], accel_y} : {accel_y[15], accel_y};
    az = accel_z[15] ? -{accel_z[15], accel_z} : {accel_z[15], accel_z};
    post_c = 2'd0;
    if (az > ax && az > ay) begin
      if (accel_z > 16'sd2048)       post_c = 2'd0;
      else if (accel_z < -16'sd2048) post_c = 2'd1;
    end else if (ay > ax) begin
      if (accel_y > 16'sd2048)       post_c = 2'd2;
      else if (accel_y < -16'sd2048) post_c = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      msq <= MSQ_W'(32'(accel_x * accel_x)) + MSQ_W'(32'(accel_y * accel_y))
           + MSQ_W'(32'(accel_z * accel_z));
      post_r <= post_c;
    end
  end

  // ---- shared bit-serial square root, two bits per cycle
  logic [MSQ_W-1:0]  sq_rem, sq_rad;
  logic [ROOT_W-1:0] sq_root;
  logic [SC_W-1:0]   sq_cnt;
  logic              sq_busy;
  logic [MSQ_W-1:0]  var_r;
  logic [ROOT_W+1:0] sq_trial, sq_rem_top;

  always_comb begin
    sq_rem_top = {sq_rem[ROOT_W-1:0], sq_rad[MSQ_W-1 -: 2]};
    sq_trial   = {sq_root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sq_busy <= 1'b1;
      sq_rad  <= cmd.sqrt_var ? var_r : msq;
      sq_rem  <= '0;
      sq_root <= '0;
      sq_cnt  <= SC_W'(SQ_STEPS);
    end else if (sq_busy) begin
      sq_rad <= sq_rad << 2;
      if (sq_rem_top >= sq_trial) begin
        sq_rem  <= MSQ_W'(sq_rem_top - sq_trial);
        sq_root <= {sq_root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem  <= MSQ_W'(sq_rem_top);
        sq_root <= {sq_root[ROOT_W-2:0], 1'b0};
      end
      sq_cnt <= sq_cnt - 1'b1;
      if (sq_cnt == SC_W'(1)) sq_busy <= 1'b0;
    end
  end
  assign stat.sqrt_done = !sq_busy && !cmd.sqrt_start;

  // ---- ring and sums
  logic [MAG_W-1:0] mag;
  assign mag  = sq_root[MAG_W-1:0];
  assign full = (fill >= win_len);

  always_ff @(posedge clk) begin
    if (cmd.ring_rd) old_mag <= ring[wptr];
    if (cmd.update) ring[wptr] <= mag;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      wptr <= '0;
      fill <= '0;
      msum <= '0;
      ssum <= '0;
    end else if (cmd.update) begin
      if (full) begin
        msum <= msum - SUM_W'(old_mag) + SUM_W'(mag);
        ssum <= ssum - SQS_W'(old_mag * old_mag) + SQS_W'(mag * mag);
      end else begin
        fill <= fill + 1'b1;
        msum <= msum + SUM_W'(mag);
        ssum <= ssum + SQS_W'(mag * mag);
      end
      if (CNT_W'(wptr) + 1'b1 >= win_len) wptr <= '0;
      else                                wptr <= wptr + 1'b1;
    end
  end
  assign stat.warm = (fill < CNT_W'(MIN_FILL));

  // ---- two restoring dividers run in lockstep, one quotient bit per cycle
  logic [DIV_W-1:0] q_s, q_m, r_s, r_m;
  logic [DIV_W:0]   ts, tm;
  logic [DC_W-1:0]  d_cnt;
  logic             d_busy;
  always_comb begin
    ts = {r_s, q_s[DIV_W-1]};
    tm = {r_m, q_m[DIV_W-1]};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      d_busy <= 1'b0;
    end else if (cmd.div_start) begin
      d_busy <= 1'b1;
      q_s    <= ssum;
      q_m    <= DIV_W'(msum);
      r_s    <= '0;
      r_m    <= '0;
      d_cnt  <= DC_W'(DIV_W);
    end else if (d_busy) begin
      if (ts >= (DIV_W+1)'(fill)) begin
        r_s <= DIV_W'(ts - (DIV_W+1)'(fill));
        q_s <= {q_s[DIV_W-2:0], 1'b1};
      end else begin
        r_s <= DIV_W'(ts);
        q_s <= {q_s[DIV_W-2:0], 1'b0};
      end
      if (tm >= (DIV_W+1)'(fill)) begin
        r_m <= DIV_W'(tm - (DIV_W+1)'(fill));
        q_m <= {q_m[DIV_W-2:0], 1'b1};
      end else begin
        r_m <= DIV_W'(tm);
        q_m <= {q_m[DIV_W-2:0], 1'b0};
      end
      d_cnt <= d_cnt - 1'b1;
      if (d_cnt == DC_W'(1)) d_busy <= 1'b0;
    end
  end
  assign stat.div_done = !d_busy;

  // ---- variance: mean fits MAG_W bits, square then compare
  logic [2*MAG_W-1:0] m2;
  logic               mov_r;
  assign m2 = q_m[MAG_W-1:0] * q_m[MAG_W-1:0];
  always_ff @(posedge clk) begin
    if (cmd.var_calc) begin
      var_r <= (MSQ_W'(q_s) > MSQ_W'(m2)) ? MSQ_W'(q_s) - MSQ_W'(m2) : '0;
    end
    if (cmd.sqrt_start && cmd.sqrt_var) begin
      mov_r <= var_r > MSQ_W'(thresh * thresh);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      posture <= post_r;
      if (stat.warm) begin
        deviation <= '0;
        in_motion <= 1'b0;
      end else begin
        deviation <= (|sq_root[ROOT_W-1:16]) ? 16'hFFFF : sq_root[15:0];
        in_motion <= mov_r;
      end
    end
  end

`ifndef ASSERT_OFF
  a_fill: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(MAX_WINDOW))
    else $error("fill count out of range");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (win_len != '0) |-> (CNT_W'(wptr) < win_len || fill == '0))
    else $error("write pointer past window");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(sq_busy && d_busy))
    else $error("root and divider overlap");
`endif

endmodule
`default_nettype wire

/* tb/tb_sliding_window_motion_detector_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sliding_window_motion_detector_core
// Self-checking bench: directed and random accelerometer items through a valid/ready
// driver, results checked against an in-bench window-variance predictor,
// window and threshold registers swept between phases.
// ----------------------------------------------------------------------------
module tb_sliding_window_motion_detector_core;
  import swmd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } accel_item_t;

  typedef struct packed {
    logic [15:0] energy;
    logic        moving;
    logic [1:0]  posture;
  } motion_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] deviation;
  logic in_motion;
  logic [1:0] posture;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = REG_WINDOW;
  logic [15:0] cfg_data = '0;

  sliding_window_motion_detector_core uut (.*);

  always #6 clk = ~clk;

  // predictor state
  int unsigned    win_len;
  int unsigned    thresh;
  logic [15:0]    mag_ring [MAX_WINDOW];
  int unsigned    wr_ptr;
  int unsigned    fill;
  longint unsigned mag_total;
  longint unsigned sq_total;

  accel_item_t    pending_items[$];
  motion_result_t expected_results[$];
  int             errors = 0;
  logic           hold_off = 1'b0;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [1:0] posture_code(longint x, longint y, longint z);
    longint ax, ay, az;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    if (az > ax && az > ay) begin
      if (z > HALF_G) return 2'd0;
      if (z < -HALF_G) return 2'd1;
    end else if (ay > ax) begin
      if (y > HALF_G) return 2'd2;
      if (y < -HALF_G) return 2'd3;
    end
    return 2'd0;
  endfunction

  function automatic void clear_window();
    foreach (mag_ring[i]) mag_ring[i] = '0;
    wr_ptr = 0;
    fill = 0;
    mag_total = 0;
    sq_total = 0;
  endfunction

  function automatic void apply_register(logic [0:0] idx, logic [15:0] data);
    int unsigned w;
    if (idx == REG_WINDOW) begin
      w = data[7:0];
      if (w == 0) w = 1;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      win_len = w;
      clear_window();
    end else if (idx == REG_THRESHOLD) begin
      if (data != 0) thresh = data;
    end
  endfunction

  function automatic motion_result_t predict_motion(accel_item_t it);
    motion_result_t r;
    longint x, y, z;
    longint unsigned mag, old, n, msq, mean, m2, variance, e;
    x = it.x;
    y = it.y;
    z = it.z;
    mag = floor_sqrt(longint'(x * x + y * y + z * z));
    if (fill >= win_len) begin
      old = mag_ring[wr_ptr];
      mag_total -= old;
      sq_total -= old * old;
    end else begin
      fill++;
    end
    mag_ring[wr_ptr] = mag[15:0];
    mag_total += mag;
    sq_total += mag * mag;
    wr_ptr = (wr_ptr + 1) % win_len;
    r = '0;
    if (fill >= MIN_FILL) begin
      n = fill;
      msq = sq_total / n;
      mean = mag_total / n;
      m2 = mean * mean;
      variance = msq > m2 ? msq - m2 : 0;
      r.moving = variance > longint'(thresh) * thresh;
      e = floor_sqrt(variance);
      r.energy = e > 65535 ? 16'hFFFF : e[15:0];
    end
    r.posture = posture_code(x, y, z);
    return r;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_results.push_back(predict_motion({accel_x, accel_y, accel_z}));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        accel_item_t it;
        it = pending_items.pop_front();
        accel_x <= it.x;
        accel_y <= it.y;
        accel_z <= it.z;
        in_valid <= 1'b1;
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        motion_result_t exp_r;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result energy=%0d moving=%0d posture=%0d",
                   $time, deviation, in_motion, posture);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (deviation !== exp_r.energy) begin
            $display("%0t: deviation expected %0d actual %0d",
                     $time, exp_r.energy, deviation);
            errors++;
          end
          if (in_motion !== exp_r.moving) begin
            $display("%0t: in_motion expected %0d actual %0d",
                     $time, exp_r.moving, in_motion);
            errors++;
          end
          if (posture !== exp_r.posture) begin
            $display("%0t: posture expected %0d actual %0d",
                     $time, exp_r.posture, posture);
            errors++;
          end
        end
        out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_register(logic [0:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, data);
  endtask

  // wait for all outstanding items to drain; checked mid-cycle so the
  // driver's and monitor's updates at the edge are already visible
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(0, 4096) - 2048);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_item(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
    accel_item_t it;
    it.x = x;
    it.y = y;
    it.z = z;
    pending_items.push_back(it);
  endtask

  // mostly a resting signal plus noise, sometimes large swings
  task automatic queue_random(int count);
    int base_x, base_y, base_z, amp;
    base_x = $urandom_range(0, 8192) - 4096;
    base_y = $urandom_range(0, 8192) - 4096;
    base_z = $urandom_range(0, 8192) - 4096;
    amp = 1 << $urandom_range(0, 14);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0)
        queue_item(rand_axis(), rand_axis(), rand_axis());
      else
        queue_item(16'(base_x + $urandom_range(0, amp) - amp / 2),
                   16'(base_y + $urandom_range(0, amp) - amp / 2),
                   16'(base_z + $urandom_range(0, amp) - amp / 2));
    end
  endtask

  initial begin
    win_len = 64;
    thresh = 205;
    clear_window();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: posture cases, extremes, ties at half g
    queue_item(0, 0, 4096);
    queue_item(0, 0, -4096);
    queue_item(0, 4096, 0);
    queue_item(0, -4096, 0);
    queue_item(4096, 0, 0);
    queue_item(0, 0, 2048);
    queue_item(0, 0, -2048);
    queue_item(0, 2049, 0);
    queue_item(0, -2049, 0);
    queue_item(1000, 1000, 1000);
    queue_item(16'sh8000, 16'sh8000, 16'sh8000);
    queue_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_item(16'sh8000, 16'sh7FFF, 0);
    queue_item(0, 0, 0);
    queue_item(16'shFFFF, 16'shFFFF, 16'shFFFF);
    queue_item(0, 16'sh8000, 16'sh7FFF);
    queue_item(3000, 3000, 0);
    queue_item(0, 3000, 3000);
    queue_item(0, 0, 16'sh8000);
    queue_item(16'sh5555, 16'shAAAA, 16'sh0F0F);
    drain();

    // unchanged registers: window 64 with default threshold
    queue_random(200);
    drain();

    write_register(REG_WINDOW, 16'd0);     // saturates to 1
    write_register(REG_THRESHOLD, 16'd1);
    queue_random(40);
    drain();

    write_register(REG_WINDOW, 16'd4);     // never leaves warm-up
    queue_random(40);
    drain();

    write_register(REG_WINDOW, 16'd5);
    write_register(REG_THRESHOLD, 16'd0);  // ignored
    queue_random(100);
    drain();

    write_register(REG_WINDOW, 16'hFFFF);  // saturates to max window
    write_register(REG_THRESHOLD, 16'hFFFF);
    queue_random(300);
    drain();

    write_register(REG_WINDOW, 16'd128);
    write_register(REG_THRESHOLD, 16'd205);
    // receiver stalls long while the sender keeps offering
    hold_off <= 1'b1;
    queue_random(40);
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
    queue_random(260);
    drain();

    repeat (6) begin
      write_register(REG_WINDOW, 16'($urandom_range(1, 200)));
      write_register(REG_THRESHOLD,
                     16'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 2000)));
      queue_random(100);
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/swmd_pkg.sv
rtl/core/swmd_ctrl.sv
rtl/core/swmd_datapath.sv
rtl/core/sliding_window_motion_detector_core.sv
tb/tb_sliding_window_motion_detector_core.sv
